/* rtl/core/assert_macros.svh */
// Assertion macros used by the RTL checker, cfq_checker.sv.
// No dependencies; each file that asserts includes this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, switched off while in reset.
`define CFQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the rising edge of clk that also holds across reset.
`define CFQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/cfq_pkg.sv */
// Shared types, constants and helpers of the converter fault qualifier.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package cfq_pkg;

  localparam int unsigned MV_W        = 16;
  localparam int unsigned REF_W       = 17;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned FCOUNT_W    = 4;
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam int unsigned BLANK_TICKS_DEF = 3;
  localparam int unsigned FAULT_LIMIT_DEF = 8;

  // threshold values after reset, mV
  localparam logic [MV_W-1:0] OVP_CELL_RST       = 16'd4400;
  localparam logic [MV_W-1:0] SHORT_OUTPUT_RST   = 16'd15000;
  localparam logic [MV_W-1:0] SHORT_FEEDBACK_RST = 16'd4800;
  localparam logic [MV_W-1:0] OPEN_FEEDBACK_RST  = 16'd500;
  localparam logic [MV_W-1:0] OPEN_OUTPUT_RST    = 16'd22800;
  localparam logic [MV_W-1:0] LIMIT_FEEDBACK_RST = 16'd100;
  localparam logic [MV_W-1:0] LIMIT_BATTERY_RST  = 16'd11500;
  localparam logic [MV_W-1:0] LIMIT_OUTPUT_RST   = 16'd18000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVP_CELL       = 3'd0,
    REG_SHORT_OUTPUT   = 3'd1,
    REG_SHORT_FEEDBACK = 3'd2,
    REG_OPEN_FEEDBACK  = 3'd3,
    REG_OPEN_OUTPUT    = 3'd4,
    REG_LIMIT_FEEDBACK = 3'd5,
    REG_LIMIT_BATTERY  = 3'd6,
    REG_LIMIT_OUTPUT   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    FAULT_CLEAR = 2'd0,
    FAULT_OVP   = 2'd1,
    FAULT_SHORT = 2'd2,
    FAULT_OPEN  = 2'd3
  } fault_code_t;

  typedef enum logic {
    KIND_SHORT = 1'b0,
    KIND_OPEN  = 1'b1
  } fault_kind_t;

  typedef struct packed {
    logic [MV_W-1:0] ovp_cell_mv;
    logic [MV_W-1:0] short_output_mv;
    logic [MV_W-1:0] short_feedback_mv;
    logic [MV_W-1:0] open_feedback_mv;
    logic [MV_W-1:0] open_output_mv;
    logic [MV_W-1:0] limit_feedback_mv;
    logic [MV_W-1:0] limit_battery_mv;
    logic [MV_W-1:0] limit_output_mv;
  } cfg_t;

  // declared high field first so that the first field lands in bit 0
  typedef struct packed {
    logic [MV_W-1:0]         feedback_mv;
    logic [MV_W-1:0]         output_mv;
    logic signed [REF_W-1:0] ramp_reference_mv;
    logic [MV_W-1:0]         battery_mv;
    logic [MV_W-1:0]         cell_mv;
    logic                    ramp_active;
    logic                    output_enabled;
  } item_t;

  typedef struct packed {
    fault_code_t fault_code;
    logic        reference_reset;
    logic        input_limited;
  } result_t;

  localparam int unsigned ITEM_W = $bits(item_t);
  localparam int unsigned RES_W  = $bits(result_t);

  // leaky counter step: add below limit, else hold limit; four-bit sum may wrap
  function automatic logic [FCOUNT_W-1:0] bump(input logic [FCOUNT_W-1:0] cnt,
                                               input logic [FCOUNT_W-1:0] step,
                                               input logic [FCOUNT_W-1:0] limit);
    logic [FCOUNT_W-1:0] res;
    res = (cnt < limit) ? (cnt + step) : limit;
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cfq_cfg_regs.sv */
// Threshold register file of the converter fault qualifier.
// Depends on cfq_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module cfq_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [cfq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfq_pkg::MV_W-1:0]       cfg_wdata,
  output cfq_pkg::cfg_t                       cfg
);

  cfq_pkg::cfg_t cfg_r;
  cfq_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfq_pkg::reg_idx_t'(cfg_index))
        cfq_pkg::REG_OVP_CELL:       cfg_nxt.ovp_cell_mv       = cfg_wdata;
        cfq_pkg::REG_SHORT_OUTPUT:   cfg_nxt.short_output_mv   = cfg_wdata;
        cfq_pkg::REG_SHORT_FEEDBACK: cfg_nxt.short_feedback_mv = cfg_wdata;
        cfq_pkg::REG_OPEN_FEEDBACK:  cfg_nxt.open_feedback_mv  = cfg_wdata;
        cfq_pkg::REG_OPEN_OUTPUT:    cfg_nxt.open_output_mv    = cfg_wdata;
        cfq_pkg::REG_LIMIT_FEEDBACK: cfg_nxt.limit_feedback_mv = cfg_wdata;
        cfq_pkg::REG_LIMIT_BATTERY:  cfg_nxt.limit_battery_mv  = cfg_wdata;
        cfq_pkg::REG_LIMIT_OUTPUT:   cfg_nxt.limit_output_mv   = cfg_wdata;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ovp_cell_mv       <= cfq_pkg::OVP_CELL_RST;
      cfg_r.short_output_mv   <= cfq_pkg::SHORT_OUTPUT_RST;
      cfg_r.short_feedback_mv <= cfq_pkg::SHORT_FEEDBACK_RST;
      cfg_r.open_feedback_mv  <= cfq_pkg::OPEN_FEEDBACK_RST;
      cfg_r.open_output_mv    <= cfq_pkg::OPEN_OUTPUT_RST;
      cfg_r.limit_feedback_mv <= cfq_pkg::LIMIT_FEEDBACK_RST;
      cfg_r.limit_battery_mv  <= cfq_pkg::LIMIT_BATTERY_RST;
      cfg_r.limit_output_mv   <= cfq_pkg::LIMIT_OUTPUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/cfq_qualify.sv */
// Per-tick checks: limit detection, blanking, overvoltage and leaky fault counter.
// Depends on cfq_pkg for the item, result and threshold types.
`default_nettype none

module cfq_qualify #(
  parameter int unsigned BLANK_TICKS = cfq_pkg::BLANK_TICKS_DEF,
  parameter int unsigned FAULT_LIMIT = cfq_pkg::FAULT_LIMIT_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     advance,   // the item is moved to the result stage
  input  cfq_pkg::item_t item,
  input  cfq_pkg::cfg_t  cfg,
  output cfq_pkg::result_t res
);

  localparam int unsigned BLANK_W = (BLANK_TICKS < 2) ? 1 : $clog2(BLANK_TICKS + 1);
  localparam logic [BLANK_W-1:0] BLANK_END = BLANK_W'(BLANK_TICKS);
  localparam logic [cfq_pkg::FCOUNT_W-1:0] LIMIT = cfq_pkg::FCOUNT_W'(FAULT_LIMIT);
  localparam logic [cfq_pkg::FCOUNT_W-1:0] STEP_SHORT = cfq_pkg::FCOUNT_W'(2);
  localparam logic [cfq_pkg::FCOUNT_W-1:0] STEP_OPEN  = cfq_pkg::FCOUNT_W'(1);

  logic [BLANK_W-1:0]           blank_count_r, blank_count_nxt;
  logic [cfq_pkg::FCOUNT_W-1:0] fault_count_r, fault_count_nxt;
  cfq_pkg::fault_kind_t         fault_kind_r,  fault_kind_nxt;

  logic sag;
  logic low_drive;
  logic is_short;
  logic is_open;
  cfq_pkg::fault_code_t code;

  always_comb begin
    // battery zero-extended into the signed reference width
    sag = !item.ramp_active &&
          ($signed({1'b0, item.battery_mv}) < $signed(item.ramp_reference_mv));
    low_drive = (item.feedback_mv < cfg.limit_feedback_mv) &&
                (item.battery_mv  < cfg.limit_battery_mv) &&
                (item.output_mv   > cfg.limit_output_mv);
    is_short = (item.output_mv < cfg.short_output_mv) &&
               (item.feedback_mv > cfg.short_feedback_mv);
    is_open  = (item.feedback_mv < cfg.open_feedback_mv) &&
               (item.output_mv > cfg.open_output_mv);

    blank_count_nxt = blank_count_r;
    fault_count_nxt = fault_count_r;
    fault_kind_nxt  = fault_kind_r;
    code            = cfq_pkg::FAULT_CLEAR;

    if (!item.output_enabled) begin
      blank_count_nxt = '0;
    end else if (blank_count_r < BLANK_END) begin
      blank_count_nxt = blank_count_r + 1'b1;
    end else begin
      if (item.cell_mv > cfg.ovp_cell_mv) begin
        code = cfq_pkg::FAULT_OVP;
      end
      // short wins over open
      if (is_short) begin
        fault_count_nxt = cfq_pkg::bump(fault_count_r, STEP_SHORT, LIMIT);
        fault_kind_nxt  = cfq_pkg::KIND_SHORT;
      end else if (is_open) begin
        fault_count_nxt = cfq_pkg::bump(fault_count_r, STEP_OPEN, LIMIT);
        fault_kind_nxt  = cfq_pkg::KIND_OPEN;
      end else if (fault_count_r != '0) begin
        fault_count_nxt = fault_count_r - 1'b1;
      end
      // kind survives decay, so a late report still names the last fault seen
      if (fault_count_nxt >= LIMIT) begin
        code = (fault_kind_nxt == cfq_pkg::KIND_OPEN) ? cfq_pkg::FAULT_OPEN
                                                      : cfq_pkg::FAULT_SHORT;
      end
    end

    res.input_limited   = sag || low_drive;
    res.reference_reset = sag;
    res.fault_code      = code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_count_r <= '0;
      fault_count_r <= '0;
      fault_kind_r  <= cfq_pkg::KIND_SHORT;
    end else if (advance) begin
      blank_count_r <= blank_count_nxt;
      fault_count_r <= fault_count_nxt;
      fault_kind_r  <= fault_kind_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/converter_fault_qualifier.sv */
// An accepted item goes into the input register, then its result into the
// result register, which drives out_tvalid; a held result delays the load.
// Throughput: one item per clock while results are taken; the input and
// result registers let a new item in while the previous result waits.
// Reset (rst_n low, synchronous): both stages empty, thresholds to defaults,
// blanking and fault counters cleared.
`default_nettype none

module converter_fault_qualifier #(
  parameter int unsigned BLANK_TICKS = cfq_pkg::BLANK_TICKS_DEF,
  parameter int unsigned FAULT_LIMIT = cfq_pkg::FAULT_LIMIT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata, from bit 0: output_enabled, ramp_active, cell_mv[16],
  // battery_mv[16], ramp_reference_mv[17 signed], output_mv[16],
  // feedback_mv[16], zero fill
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [cfq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata, from bit 0: input_limited, reference_reset, fault_code[2],
  // zero fill
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [cfq_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [cfq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cfq_pkg::MV_W-1:0]        cfg_wdata
);

  localparam int unsigned PAD_W = cfq_pkg::OUT_TDATA_W - cfq_pkg::RES_W;

  cfq_pkg::cfg_t    cfg;
  cfq_pkg::item_t   in_item_r;
  cfq_pkg::result_t res;
  cfq_pkg::result_t out_res_r;
  logic             in_vld_r, in_vld_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             out_load;

  cfq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cfq_qualify #(
    .BLANK_TICKS (BLANK_TICKS),
    .FAULT_LIMIT (FAULT_LIMIT)
  ) u_qual (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (out_load),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // result register frees up when empty or taken this cycle
  assign out_load  = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || out_load;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    out_vld_nxt = out_vld_r;
    if (in_tready) begin
      in_vld_nxt = in_tvalid;
    end
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= cfq_pkg::item_t'(in_tdata[cfq_pkg::ITEM_W-1:0]);
    end
    if (out_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_res_r};

endmodule

`default_nettype wire

/* rtl/core/cfq_checker.sv */
// Port-level checks of the converter fault qualifier, bound to the top level.
// Depends on assert_macros.svh and cfq_pkg.
`default_nettype none
`include "assert_macros.svh"

module cfq_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [cfq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned RES_W = cfq_pkg::RES_W;

  // a stalled result keeps its value
  `CFQ_ASSERT(a_out_hold, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed while stalled")

  // a sag always counts as input limiting
  `CFQ_ASSERT(a_reset_implies_limit, out_tvalid && out_tdata[1] |-> out_tdata[0], "reference_reset without input_limited")

  // fill bits above the result stay zero
  `CFQ_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[cfq_pkg::OUT_TDATA_W-1:RES_W] == '0, "nonzero fill bits in out_tdata")

  // no result appears out of reset, and the input stage is free then
  `CFQ_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid && in_tready, "pipeline not empty after reset")

  // with the output not stalled the input never blocks
  `CFQ_ASSERT(a_no_false_stall, out_tready && !out_tvalid |-> in_tready, "input stalled with result side free")

endmodule

bind converter_fault_qualifier cfq_checker u_cfq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
